// ===== design/grd_pkg.sv =====
// Shared constants, types and helpers for the grid ray stepper.
package grd_pkg;
    localparam int FRAC_BITS = 14;
    localparam int CELL_W    = 16;
    localparam int OFS_W     = 15;
    localparam int DIR_W     = 16;
    localparam int DIST_W    = 17;
    localparam int PROD_W    = DIST_W + DIR_W;
    localparam int QUO_W     = 30;
    localparam int HALF      = 1 << (FRAC_BITS - 1);

    localparam logic [0:0] REG_COS = 1'b0;
    localparam logic [0:0] REG_SIN = 1'b1;

    localparam logic [1:0] AXIS_X  = 2'd0;
    localparam logic [1:0] AXIS_Y  = 2'd1;
    localparam logic [1:0] AXIS_XY = 2'd2;

    localparam logic signed [OFS_W-1:0] HALF_P = OFS_W'(HALF);
    localparam logic signed [OFS_W-1:0] HALF_N = -OFS_W'(HALF);

    typedef struct packed {
        logic [CELL_W-1:0]       next_x;
        logic [CELL_W-1:0]       next_y;
        logic signed [OFS_W-1:0] ofs_x;
        logic signed [OFS_W-1:0] ofs_y;
        logic [1:0]              axis;
        logic                    use_div;
        logic                    q_neg;
        logic signed [OFS_W-1:0] f_other;
    } t_side;

    function automatic logic signed [OFS_W-1:0] sat_half(input logic signed [31:0] v);
        logic signed [OFS_W-1:0] r;
        if (v > 32'sd0 + HALF) begin
            r = HALF_P;
        end else if (v < -(32'sd0 + HALF)) begin
            r = HALF_N;
        end else begin
            r = v[OFS_W-1:0];
        end
        return r;
    endfunction
endpackage

// ===== design/grd_in_if.sv =====
// Request channel carrying a cell and an offset.
interface grd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [grd_pkg::CELL_W-1:0]  cell_x;
    logic signed [grd_pkg::CELL_W-1:0]  cell_y;
    logic signed [grd_pkg::OFS_W-1:0]   offset_x;
    logic signed [grd_pkg::OFS_W-1:0]   offset_y;
    modport source (output valid, cell_x, cell_y, offset_x, offset_y, input ready);
    modport sink   (input valid, cell_x, cell_y, offset_x, offset_y, output ready);
endinterface

// ===== design/grd_out_if.sv =====
// Result channel carrying the entered cell and entry offset.
interface grd_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [grd_pkg::CELL_W-1:0]  next_cell_x;
    logic signed [grd_pkg::CELL_W-1:0]  next_cell_y;
    logic signed [grd_pkg::OFS_W-1:0]   entry_offset_x;
    logic signed [grd_pkg::OFS_W-1:0]   entry_offset_y;
    logic [1:0]                          crossed_axis;
    modport source (output valid, next_cell_x, next_cell_y, entry_offset_x, entry_offset_y,
                    crossed_axis, input ready);
    modport sink   (input valid, next_cell_x, next_cell_y, entry_offset_x, entry_offset_y,
                    crossed_axis, output ready);
endinterface

// ===== design/grd_front.sv =====
// Front stages: border distances, cross products, step decision.
module grd_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [grd_pkg::CELL_W-1:0]    i_cell_x,
    input  logic signed [grd_pkg::CELL_W-1:0]    i_cell_y,
    input  logic signed [grd_pkg::OFS_W-1:0]     i_ofs_x,
    input  logic signed [grd_pkg::OFS_W-1:0]     i_ofs_y,
    input  logic signed [grd_pkg::DIR_W-1:0]     i_cos,
    input  logic signed [grd_pkg::DIR_W-1:0]     i_sin,
    output logic                                 o_valid,
    output grd_pkg::t_side                       o_side,
    output logic [grd_pkg::QUO_W-1:0]            o_dividend,
    output logic [grd_pkg::DIR_W-1:0]            o_divisor
);
    localparam int CW = grd_pkg::CELL_W;
    localparam int OW = grd_pkg::OFS_W;
    localparam int DW = grd_pkg::DIR_W;
    localparam int SW = grd_pkg::DIST_W;
    localparam int PW = grd_pkg::PROD_W;

    logic                 r1_v, r2_v, r3_v;
    logic signed [CW-1:0] r1_cx, r1_cy, r2_cx, r2_cy;
    logic signed [OW-1:0] r1_fx, r1_fy, r2_fx, r2_fy;
    logic signed [SW-1:0] r1_dx, r1_dy;
    logic signed [DW-1:0] r1_c, r1_s, r2_c, r2_s;
    logic signed [PW-1:0] r2_lhs, r2_rhs;
    grd_pkg::t_side       r3_side, n3_side;
    logic [grd_pkg::QUO_W-1:0] r3_dvd, n3_dvd;
    logic [DW-1:0]        r3_dvs, n3_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cx <= i_cell_x;
            r1_cy <= i_cell_y;
            r1_fx <= i_ofs_x;
            r1_fy <= i_ofs_y;
            r1_c  <= i_cos;
            r1_s  <= i_sin;
            r1_dx <= ((i_cos < 0) ? -SW'(grd_pkg::HALF) : SW'(grd_pkg::HALF))
                     - SW'(i_ofs_x);
            r1_dy <= ((i_sin < 0) ? -SW'(grd_pkg::HALF) : SW'(grd_pkg::HALF))
                     - SW'(i_ofs_y);
            r2_cx  <= r1_cx;
            r2_cy  <= r1_cy;
            r2_fx  <= r1_fx;
            r2_fy  <= r1_fy;
            r2_c   <= r1_c;
            r2_s   <= r1_s;
            r2_lhs <= PW'(r1_dx) * PW'(r1_s);
            r2_rhs <= PW'(r1_dy) * PW'(r1_c);
            r3_side <= n3_side;
            r3_dvd  <= n3_dvd;
            r3_dvs  <= n3_dvs;
        end
    end

    always_comb begin
        logic          c_pos, s_pos, pos, xfirst, tie;
        logic [CW-1:0] stx, sty;
        logic signed [OW-1:0] ex, ey;
        logic [PW-1:0] mag;
        c_pos  = r2_c > 0;
        s_pos  = r2_s > 0;
        pos    = c_pos == s_pos;
        xfirst = pos ? (r2_lhs < r2_rhs) : (r2_lhs > r2_rhs);
        tie    = r2_lhs == r2_rhs;
        stx    = c_pos ? r2_cx + 1'b1 : r2_cx - 1'b1;
        sty    = s_pos ? r2_cy + 1'b1 : r2_cy - 1'b1;
        ex     = c_pos ? grd_pkg::HALF_N : grd_pkg::HALF_P;
        ey     = s_pos ? grd_pkg::HALF_N : grd_pkg::HALF_P;
        n3_side.next_x  = r2_cx;
        n3_side.next_y  = r2_cy;
        n3_side.ofs_x   = grd_pkg::sat_half(32'(r2_fx));
        n3_side.ofs_y   = grd_pkg::sat_half(32'(r2_fy));
        n3_side.use_div = 1'b0;
        n3_side.q_neg   = 1'b0;
        n3_side.f_other = r2_fy;
        n3_dvd          = '0;
        n3_dvs          = DW'(1);
        mag             = '0;
        if (r2_c == 0) begin
            n3_side.next_y = sty;
            n3_side.ofs_y  = ey;
            n3_side.axis   = grd_pkg::AXIS_Y;
        end else if (r2_s == 0) begin
            n3_side.next_x = stx;
            n3_side.ofs_x  = ex;
            n3_side.axis   = grd_pkg::AXIS_X;
        end else if (xfirst) begin
            n3_side.next_x  = stx;
            n3_side.ofs_x   = ex;
            n3_side.axis    = grd_pkg::AXIS_X;
            n3_side.use_div = 1'b1;
            n3_side.q_neg   = r2_lhs[PW-1] ^ r2_c[DW-1];
            n3_side.f_other = r2_fy;
            mag             = r2_lhs[PW-1] ? -r2_lhs : r2_lhs;
            n3_dvd          = mag[grd_pkg::QUO_W-1:0];
            n3_dvs          = r2_c[DW-1] ? -r2_c : r2_c;
        end else if (tie) begin
            n3_side.next_x = stx;
            n3_side.next_y = sty;
            n3_side.ofs_x  = ex;
            n3_side.ofs_y  = ey;
            n3_side.axis   = grd_pkg::AXIS_XY;
        end else begin
            n3_side.next_y  = sty;
            n3_side.ofs_y   = ey;
            n3_side.axis    = grd_pkg::AXIS_Y;
            n3_side.use_div = 1'b1;
            n3_side.q_neg   = r2_rhs[PW-1] ^ r2_s[DW-1];
            n3_side.f_other = r2_fx;
            mag             = r2_rhs[PW-1] ? -r2_rhs : r2_rhs;
            n3_dvd          = mag[grd_pkg::QUO_W-1:0];
            n3_dvs          = r2_s[DW-1] ? -r2_s : r2_s;
        end
    end

    assign o_valid    = r3_v;
    assign o_side     = r3_side;
    assign o_dividend = r3_dvd;
    assign o_divisor  = r3_dvs;
endmodule

// ===== design/grd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module grd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  grd_pkg::t_side              i_side,
    input  logic [grd_pkg::QUO_W-1:0]   i_dividend,
    input  logic [grd_pkg::DIR_W-1:0]   i_divisor,
    output logic                        o_valid,
    output grd_pkg::t_side              o_side,
    output logic [grd_pkg::QUO_W-1:0]   o_quotient
);
    localparam int NB = grd_pkg::QUO_W;
    localparam int DW = grd_pkg::DIR_W;

    logic                v   [1:NB];
    grd_pkg::t_side      sd  [1:NB];
    logic [NB-1:0]       dq  [1:NB];
    logic [DW-1:0]       rem [1:NB];
    logic [DW-1:0]       dvs [1:NB];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic           cv;
        grd_pkg::t_side csd;
        logic [NB-1:0]  cdq;
        logic [DW-1:0]  crem;
        logic [DW-1:0]  cdvs;
        logic [DW:0]    t;
        logic           ge;
        logic [DW:0]    diff;

        if (k == 0) begin : g_head
            assign cv   = i_valid;
            assign csd  = i_side;
            assign cdq  = i_dividend;
            assign crem = '0;
            assign cdvs = i_divisor;
        end else begin : g_body
            assign cv   = v[k];
            assign csd  = sd[k];
            assign cdq  = dq[k];
            assign crem = rem[k];
            assign cdvs = dvs[k];
        end

        assign t    = {crem, cdq[NB-1]};
        assign diff = t - {1'b0, cdvs};
        assign ge   = t >= {1'b0, cdvs};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                v[k+1] <= 1'b0;
            end else if (i_en) begin
                v[k+1] <= cv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                sd[k+1]  <= csd;
                dvs[k+1] <= cdvs;
                dq[k+1]  <= {cdq[NB-2:0], ge};
                rem[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
            end
        end
    end

    assign o_valid    = v[NB];
    assign o_side     = sd[NB];
    assign o_quotient = dq[NB];
endmodule

// ===== design/grd_back.sv =====
// Output stage: carried offset, saturation and result register.
module grd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  grd_pkg::t_side              i_side,
    input  logic [grd_pkg::QUO_W-1:0]   i_quotient,
    grd_out_if.source                   o_out
);
    localparam int OW = grd_pkg::OFS_W;

    logic                 r_v;
    logic [grd_pkg::CELL_W-1:0] r_nx, r_ny;
    logic signed [OW-1:0] r_ox, r_oy, n_ox, n_oy;
    logic [1:0]           r_axis;

    always_comb begin
        logic signed [31:0] q, sum;
        logic signed [OW-1:0] carried;
        q       = i_side.q_neg ? -32'(i_quotient) : 32'(i_quotient);
        sum     = 32'(i_side.f_other) + q;
        carried = grd_pkg::sat_half(sum);
        n_ox    = i_side.ofs_x;
        n_oy    = i_side.ofs_y;
        if (i_side.use_div) begin
            if (i_side.axis == grd_pkg::AXIS_X) begin
                n_oy = carried;
            end else begin
                n_ox = carried;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx   <= i_side.next_x;
            r_ny   <= i_side.next_y;
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_axis <= i_side.axis;
        end
    end

    assign o_out.valid          = r_v;
    assign o_out.next_cell_x    = r_nx;
    assign o_out.next_cell_y    = r_ny;
    assign o_out.entry_offset_x = r_ox;
    assign o_out.entry_offset_y = r_oy;
    assign o_out.crossed_axis   = r_axis;
endmodule

// ===== design/grid_ray_next_cell.sv =====
// Top level of the grid ray stepper: one step of a 2D grid traversal.
// Accepts one request per clock unless a result waits to be taken, which holds the whole pipeline.
// Returns the entered cell, entry offset and crossed axis after three front stages (border
// distances, two 17x16 cross products, step decision), a 30-stage divider producing one
// quotient bit per stage, and one output register. The user must write the direction registers
// through the plain write port while no request is in flight; the block does not enforce it.
module grid_ray_next_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [0:0]                        i_cfg_idx,
    input  logic [grd_pkg::DIR_W-1:0]         i_cfg_data,
    grd_in_if.sink                            i_in,
    grd_out_if.source                         o_out
);
    logic signed [grd_pkg::DIR_W-1:0] r_cos, r_sin;
    logic                 en;
    logic                 f_v, d_v;
    grd_pkg::t_side       f_side, d_side;
    logic [grd_pkg::QUO_W-1:0] f_dvd, d_quo;
    logic [grd_pkg::DIR_W-1:0] f_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= grd_pkg::DIR_W'(1 << grd_pkg::FRAC_BITS);
            r_sin <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                grd_pkg::REG_COS: r_cos <= i_cfg_data;
                grd_pkg::REG_SIN: r_sin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    grd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(i_in.valid),
        .i_cell_x(i_in.cell_x), .i_cell_y(i_in.cell_y),
        .i_ofs_x(i_in.offset_x), .i_ofs_y(i_in.offset_y),
        .i_cos(r_cos), .i_sin(r_sin),
        .o_valid(f_v), .o_side(f_side), .o_dividend(f_dvd), .o_divisor(f_dvs)
    );

    grd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(f_v), .i_side(f_side), .i_dividend(f_dvd), .i_divisor(f_dvs),
        .o_valid(d_v), .o_side(d_side), .o_quotient(d_quo)
    );

    grd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(d_v), .i_side(d_side), .i_quotient(d_quo),
        .o_out(o_out)
    );

    a_axis_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.crossed_axis != 2'd3)
        else $error("crossed axis code out of range");
    a_diag_ofs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.crossed_axis == grd_pkg::AXIS_XY |->
        (o_out.entry_offset_x == grd_pkg::HALF_P || o_out.entry_offset_x == grd_pkg::HALF_N)
        && (o_out.entry_offset_y == grd_pkg::HALF_P
            || o_out.entry_offset_y == grd_pkg::HALF_N))
        else $error("diagonal step without border offsets");
    a_ofs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.entry_offset_x <= grd_pkg::HALF_P
        && o_out.entry_offset_x >= grd_pkg::HALF_N
        && o_out.entry_offset_y <= grd_pkg::HALF_P
        && o_out.entry_offset_y >= grd_pkg::HALF_N)
        else $error("entry offset not saturated");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");
endmodule

// ===== dv/grd_tb_if.sv =====
// Testbench-side expected step type used by the grid ray stepper test.
`timescale 1ns / 1ps
package grd_tb_pkg;
    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [14:0] ox;
        logic signed [14:0] oy;
        logic [1:0]         axis;
    } t_step;
endpackage

// ===== dv/grid_ray_next_cell_test.sv =====
// Self-checking test of the grid ray stepper: predicts each step and compares results.
`timescale 1ns / 1ps
module grid_ray_next_cell_test;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [0:0] i_cfg_idx = grd_pkg::REG_COS;
    logic [grd_pkg::DIR_W-1:0] i_cfg_data = '0;

    grd_in_if  req_ch ();
    grd_out_if res_ch ();

    grid_ray_next_cell u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_ch.sink),
        .o_out      (res_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic signed [15:0] dir_cos = 16'sd16384;
    logic signed [15:0] dir_sin = 16'sd0;
    grd_tb_pkg::t_step pending_steps[$];
    int    fail_count = 0;
    int    send_idle_pct = 0;
    int    take_stall_pct = 0;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.cell_x = '0;
        req_ch.cell_y = '0;
        req_ch.offset_x = '0;
        req_ch.offset_y = '0;
        res_ch.ready = 1'b0;
    end

    function automatic longint clamp_half(longint v);
        if (v > grd_pkg::HALF) return grd_pkg::HALF;
        if (v < -grd_pkg::HALF) return -grd_pkg::HALF;
        return v;
    endfunction

    function automatic grd_tb_pkg::t_step next_step(logic signed [15:0] cx,
                                                    logic signed [15:0] cy,
                                                    logic signed [14:0] fx,
                                                    logic signed [14:0] fy);
        grd_tb_pkg::t_step r;
        longint c, s, bx, by, dx, dy, lhs, rhs, ox, oy;
        int sx, sy;
        bit pos, xfirst;
        c = dir_cos;
        s = dir_sin;
        sx = (c > 0) ? 1 : -1;
        sy = (s > 0) ? 1 : -1;
        bx = (c < 0) ? -grd_pkg::HALF : grd_pkg::HALF;
        by = (s < 0) ? -grd_pkg::HALF : grd_pkg::HALF;
        r.cx = cx;
        r.cy = cy;
        ox = clamp_half(fx);
        oy = clamp_half(fy);
        if (c == 0) begin
            r.cy = cy + 16'(sy);
            oy = (sy > 0) ? -grd_pkg::HALF : grd_pkg::HALF;
            r.axis = grd_pkg::AXIS_Y;
        end else if (s == 0) begin
            r.cx = cx + 16'(sx);
            ox = (sx > 0) ? -grd_pkg::HALF : grd_pkg::HALF;
            r.axis = grd_pkg::AXIS_X;
        end else begin
            dx = bx - fx;
            dy = by - fy;
            lhs = dx * s;
            rhs = dy * c;
            pos = (c > 0) == (s > 0);
            xfirst = pos ? (lhs < rhs) : (lhs > rhs);
            if (xfirst) begin
                r.cx = cx + 16'(sx);
                ox = (sx > 0) ? -grd_pkg::HALF : grd_pkg::HALF;
                oy = clamp_half(fy + lhs / c);
                r.axis = grd_pkg::AXIS_X;
            end else if (lhs == rhs) begin
                r.cx = cx + 16'(sx);
                r.cy = cy + 16'(sy);
                ox = (sx > 0) ? -grd_pkg::HALF : grd_pkg::HALF;
                oy = (sy > 0) ? -grd_pkg::HALF : grd_pkg::HALF;
                r.axis = grd_pkg::AXIS_XY;
            end else begin
                r.cy = cy + 16'(sy);
                oy = (sy > 0) ? -grd_pkg::HALF : grd_pkg::HALF;
                ox = clamp_half(fx + rhs / s);
                r.axis = grd_pkg::AXIS_Y;
            end
        end
        r.ox = ox[14:0];
        r.oy = oy[14:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        grd_tb_pkg::t_step want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_steps.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                want = pending_steps.pop_front();
                if (res_ch.next_cell_x !== want.cx) begin
                    $error("next_cell_x exp %0d got %0d", want.cx, res_ch.next_cell_x);
                    fail_count++;
                end
                if (res_ch.next_cell_y !== want.cy) begin
                    $error("next_cell_y exp %0d got %0d", want.cy, res_ch.next_cell_y);
                    fail_count++;
                end
                if (res_ch.entry_offset_x !== want.ox) begin
                    $error("entry_offset_x exp %0d got %0d", want.ox,
                           res_ch.entry_offset_x);
                    fail_count++;
                end
                if (res_ch.entry_offset_y !== want.oy) begin
                    $error("entry_offset_y exp %0d got %0d", want.oy,
                           res_ch.entry_offset_y);
                    fail_count++;
                end
                if (res_ch.crossed_axis !== want.axis) begin
                    $error("crossed_axis exp %0d got %0d", want.axis, res_ch.crossed_axis);
                    fail_count++;
                end
            end
        end
        res_ch.ready <= ($urandom_range(99) >= take_stall_pct);
    end

    task automatic send_request(logic signed [15:0] cx, logic signed [15:0] cy,
                                logic signed [14:0] fx, logic signed [14:0] fy);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cell_x <= cx;
        req_ch.cell_y <= cy;
        req_ch.offset_x <= fx;
        req_ch.offset_y <= fy;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_steps.push_back(next_step(cx, cy, fx, fy));
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_dir(logic signed [15:0] c, logic signed [15:0] s);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= grd_pkg::REG_COS;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_idx <= grd_pkg::REG_SIN;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dir_cos = c;
        dir_sin = s;
    endtask

    function automatic logic signed [14:0] rand_offset();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 15'(grd_pkg::HALF);
        if (k == 1) return -15'(grd_pkg::HALF);
        if (k == 2) return 15'($urandom);
        return 15'($urandom_range(2 * grd_pkg::HALF) - grd_pkg::HALF);
    endfunction

    task automatic test_directed();
        logic signed [15:0] dirs[8][2] = '{'{16384, 0}, '{-16384, 0}, '{0, 16384},
            '{0, -16384}, '{0, 0}, '{11585, 11585}, '{-11585, 11585}, '{16384, -16384}};
        for (int d = 0; d < 8; d++) begin
            write_dir(dirs[d][0], dirs[d][1]);
            send_request(16'sh7fff, -16'sh8000, 15'(grd_pkg::HALF), -15'(grd_pkg::HALF));
            send_request(-16'sh8000, 16'sh7fff, 15'sh3fff, -15'sh4000);
            send_request(16'sd0, 16'sd0, 15'sd0, 15'sd0);
            drain();
        end
    endtask

    task automatic test_random(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) begin
                drain();
                k = $urandom_range(5);
                if (k == 0)
                    write_dir(16'($urandom_range(2) * 16384 - 16384),
                              16'($urandom_range(2) * 16384 - 16384));
                else if (k == 1)
                    write_dir(16'($urandom), 16'($urandom));
                else
                    write_dir(16'($urandom_range(32768) - 16384),
                              16'($urandom_range(32768) - 16384));
            end
            send_request(16'($urandom), 16'($urandom), rand_offset(), rand_offset());
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drain();
        test_directed();
        send_idle_pct = 26;
        take_stall_pct = 54;
        test_random(400);
        send_idle_pct = 54;
        take_stall_pct = 26;
        test_random(400);
        send_idle_pct = 0;
        take_stall_pct = 0;
        test_random(400);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
